@@ rtl/accel_tilt_roll_pitch_macros.svh @@
// Assertion macros for the tilt block RTL, used by the top level.
// Needs a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef ACCEL_TILT_ROLL_PITCH_MACROS_SVH
`define ACCEL_TILT_ROLL_PITCH_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ATRP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that a condition in one cycle implies another condition in the next cycle.
`define ATRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/atrp_pkg.sv @@
// Types, widths and the arctangent table for the tilt block.
// No dependencies; every RTL module of the block uses it.
`default_nettype none

package atrp_pkg;

	localparam int DATA_W       = 16;
	localparam int ITER_DEFAULT = 16;
	localparam int ITER_MAX     = 24;
	localparam int FRAC_SHIFT   = 24;
	localparam int VEC_W        = 43;
	localparam int ACC_W        = 26;
	localparam int ANGLE_MAX    = 23040;
	localparam int ACC_QUARTER  = 5898240;
	localparam int ROUND_HALF   = 256;
	localparam int ROUND_SHIFT  = 9;
	localparam int RND_W        = ACC_W - ROUND_SHIFT;

	typedef logic signed [DATA_W-1:0] axis_t;
	typedef logic signed [VEC_W-1:0]  vec_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	typedef struct packed {
		vec_t a;
		vec_t b;
		acc_t acc;
		logic zero;
	} lane_t;

	typedef struct packed {
		lane_t pitch;
		lane_t roll;
	} pair_t;

	typedef struct packed {
		axis_t pitch_angle;
		axis_t roll_angle;
	} result_t;

	// round(atan(2^-i) degrees * 65536)
	function automatic acc_t atan_entry(input int idx);
		acc_t v;
		case (idx)
			0:       v = ACC_W'(2949120);
			1:       v = ACC_W'(1740967);
			2:       v = ACC_W'(919879);
			3:       v = ACC_W'(466945);
			4:       v = ACC_W'(234379);
			5:       v = ACC_W'(117304);
			6:       v = ACC_W'(58666);
			7:       v = ACC_W'(29335);
			8:       v = ACC_W'(14668);
			9:       v = ACC_W'(7334);
			10:      v = ACC_W'(3667);
			11:      v = ACC_W'(1833);
			12:      v = ACC_W'(917);
			13:      v = ACC_W'(458);
			14:      v = ACC_W'(229);
			15:      v = ACC_W'(115);
			16:      v = ACC_W'(57);
			17:      v = ACC_W'(29);
			18:      v = ACC_W'(14);
			19:      v = ACC_W'(7);
			20:      v = ACC_W'(4);
			21:      v = ACC_W'(2);
			22:      v = ACC_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ rtl/accel_tilt_roll_pitch.sv @@
// Top level of the accelerometer tilt block: roll and pitch by pipelined CORDIC.
// Depends on atrp_pkg, atrp_pre, atrp_rot, atrp_post and the macros header.
//
//   channel   dir   tdata fields (lowest bit up)          handshake
//   s_axis    in    accel_x, accel_y, accel_z (48 bits)   s_tvalid / s_tready
//   m_axis    out   roll_angle, pitch_angle (32 bits)     m_tvalid / m_tready
//
// One item enters per cycle unless a stalled output has backed up to the input; the
// registered stages are pre-rotation, one stage per micro-rotation, and rounding.
// Each stage holds its own valid bit, so bubbles close up behind a stalled output.
// arst_n clears all valid bits; payload registers are not reset.
`default_nettype none

`include "accel_tilt_roll_pitch_macros.svh"

module accel_tilt_roll_pitch #(
	parameter int ANGLE_ITERATIONS = atrp_pkg::ITER_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // roll_angle[15:0], pitch_angle[31:16]
);

	localparam int N = ANGLE_ITERATIONS;

	logic [N:0]        chain_valid;
	logic [N:0]        chain_ready;
	atrp_pkg::pair_t   chain_data [N+1];
	atrp_pkg::result_t res;

	atrp_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.accel_x   (s_tdata[15:0]),
		.accel_y   (s_tdata[31:16]),
		.accel_z   (s_tdata[47:32]),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_data  (chain_data[0])
	);

	for (genvar g = 0; g < N; g++) begin : g_rot
		atrp_rot #(
			.IDX (g)
		) u_rot (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[g]),
			.in_ready  (chain_ready[g]),
			.in_data   (chain_data[g]),
			.out_valid (chain_valid[g+1]),
			.out_ready (chain_ready[g+1]),
			.out_data  (chain_data[g+1])
		);
	end

	atrp_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[N]),
		.in_ready  (chain_ready[N]),
		.in_data   (chain_data[N]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	assign m_tdata = res;

	`ATRP_ASSERT(a_roll_range, m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd23040 && $signed(m_tdata[15:0]) >= -16'sd23040), "roll angle out of range")
	`ATRP_ASSERT(a_pitch_range, m_tvalid |-> ($signed(m_tdata[31:16]) <= 16'sd23040 && $signed(m_tdata[31:16]) >= -16'sd23040), "pitch angle out of range")
	`ATRP_ASSERT(a_ready_when_drained, !m_tvalid |-> s_tready, "input stalled with empty output stage")
	`ATRP_ASSERT_NEXT(a_no_phantom, !(|chain_valid) && !m_tvalid && !(s_tvalid && s_tready), !m_tvalid, "result without item")

endmodule

`default_nettype wire

@@ rtl/atrp_pre.sv @@
// Input stage: scale the axes and pre-rotate both operand pairs into the right half plane.
// Depends on atrp_pkg.
`default_nettype none

module atrp_pre (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire atrp_pkg::axis_t accel_x,
	input  wire atrp_pkg::axis_t accel_y,
	input  wire atrp_pkg::axis_t accel_z,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output atrp_pkg::pair_t      out_data
);

	logic            valid_s1;
	atrp_pkg::pair_t pair_s1;
	atrp_pkg::pair_t pair_next;

	function automatic atrp_pkg::lane_t prerotate(input atrp_pkg::axis_t num,
		input atrp_pkg::axis_t den);
		atrp_pkg::lane_t l;
		atrp_pkg::vec_t  a0;
		atrp_pkg::vec_t  b0;
		a0 = atrp_pkg::vec_t'(den) <<< atrp_pkg::FRAC_SHIFT;
		b0 = atrp_pkg::vec_t'(num) <<< atrp_pkg::FRAC_SHIFT;
		l.zero = (num == '0) && (den == '0);
		if (a0 < 0) begin
			if (b0 >= 0) begin
				l.a   = b0;
				l.b   = -a0;
				l.acc = atrp_pkg::ACC_W'(atrp_pkg::ACC_QUARTER);
			end else begin
				l.a   = -b0;
				l.b   = a0;
				l.acc = -atrp_pkg::ACC_W'(atrp_pkg::ACC_QUARTER);
			end
		end else begin
			l.a   = a0;
			l.b   = b0;
			l.acc = '0;
		end
		return l;
	endfunction

	always_comb begin
		pair_next.roll  = prerotate(accel_y, accel_z);
		pair_next.pitch = prerotate(accel_x, accel_z);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pair_s1 <= pair_next;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = pair_s1;

endmodule

`default_nettype wire

@@ rtl/atrp_rot.sv @@
// One CORDIC micro-rotation stage for both angles, with its own pipeline register.
// Depends on atrp_pkg for the lane types and the arctangent table.
`default_nettype none

module atrp_rot #(
	parameter int IDX = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire atrp_pkg::pair_t in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output atrp_pkg::pair_t      out_data
);

	localparam atrp_pkg::acc_t STEP = atrp_pkg::atan_entry(IDX);

	logic            valid_s1;
	atrp_pkg::pair_t pair_s1;
	atrp_pkg::pair_t pair_next;

	function automatic atrp_pkg::lane_t rotate(input atrp_pkg::lane_t l);
		atrp_pkg::lane_t r;
		atrp_pkg::vec_t  da;
		atrp_pkg::vec_t  db;
		atrp_pkg::vec_t  a_in;
		atrp_pkg::vec_t  b_in;
		a_in   = l.a;
		b_in   = l.b;
		da     = b_in >>> IDX;
		db     = a_in >>> IDX;
		r.zero = l.zero;
		if (b_in >= 0) begin
			r.a   = a_in + da;
			r.b   = b_in - db;
			r.acc = l.acc + STEP;
		end else begin
			r.a   = a_in - da;
			r.b   = b_in + db;
			r.acc = l.acc - STEP;
		end
		return r;
	endfunction

	always_comb begin
		pair_next.roll  = rotate(in_data.roll);
		pair_next.pitch = rotate(in_data.pitch);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pair_s1 <= pair_next;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = pair_s1;

endmodule

`default_nettype wire

@@ rtl/atrp_post.sv @@
// Output stage: round the angle accumulators to 1/128 degree and saturate; a zero input vector gives 0.
// Depends on atrp_pkg.
`default_nettype none

module atrp_post (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire atrp_pkg::pair_t in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output atrp_pkg::result_t    out_data
);

	localparam logic signed [atrp_pkg::RND_W-1:0] RND_MAX =
		atrp_pkg::RND_W'(atrp_pkg::ANGLE_MAX);

	logic                 valid_s1;
	atrp_pkg::result_t    res_s1;
	atrp_pkg::result_t    res_next;

	function automatic atrp_pkg::axis_t finish(input atrp_pkg::lane_t l);
		atrp_pkg::acc_t                      sum;
		logic signed [atrp_pkg::RND_W-1:0]   rnd;
		atrp_pkg::axis_t                     r;
		sum = l.acc + atrp_pkg::ACC_W'(atrp_pkg::ROUND_HALF);
		rnd = atrp_pkg::RND_W'(sum >>> atrp_pkg::ROUND_SHIFT);
		if (l.zero) begin
			r = '0;
		end else if (rnd > RND_MAX) begin
			r = atrp_pkg::DATA_W'(RND_MAX);
		end else if (rnd < -RND_MAX) begin
			r = atrp_pkg::DATA_W'(-RND_MAX);
		end else begin
			r = atrp_pkg::DATA_W'(rnd);
		end
		return r;
	endfunction

	always_comb begin
		res_next.roll_angle  = finish(in_data.roll);
		res_next.pitch_angle = finish(in_data.pitch);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_s1 <= res_next;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = res_s1;

endmodule

`default_nettype wire
